FILE: rtl/sha_pkg.sv
// Package: SHA-256 engine types, constants and round functions.
`default_nettype none
package sha_pkg;
    typedef struct packed {
        logic [7:0] data_byte;
        logic       byte_present;
        logic       end_of_message;
    } t_in_beat;

    typedef struct packed {
        logic [31:0] digest_word;
        logic [2:0]  word_index;
        logic        last_word;
    } t_out_beat;

    typedef enum logic [3:0] {
        ST_IDLE, ST_LOAD, ST_ROUND, ST_ADD, ST_PAD, ST_LEN, ST_EMIT, ST_CLEAR
    } t_state;

    typedef struct packed {
        logic       start;
    } t_core_ctl;

    localparam logic [31:0] H_INIT [8] = '{
        32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
        32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19};

    localparam logic [31:0] K_TAB [64] = '{
        32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5, 32'h3956c25b, 32'h59f111f1,
        32'h923f82a4, 32'hab1c5ed5, 32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
        32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174, 32'he49b69c1, 32'hefbe4786,
        32'h0fc19dc6, 32'h240ca1cc, 32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
        32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7, 32'hc6e00bf3, 32'hd5a79147,
        32'h06ca6351, 32'h14292967, 32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
        32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85, 32'ha2bfe8a1, 32'ha81a664b,
        32'hc24b8b70, 32'hc76c51a3, 32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
        32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5, 32'h391c0cb3, 32'h4ed8aa4a,
        32'h5b9cca4f, 32'h682e6ff3, 32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
        32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2};

    function automatic logic [31:0] rotr(input logic [31:0] x, input int n);
        rotr = (x >> n) | (x << (32 - n));
    endfunction
    function automatic logic [31:0] ssig0(input logic [31:0] x);
        ssig0 = rotr(x, 7) ^ rotr(x, 18) ^ (x >> 3);
    endfunction
    function automatic logic [31:0] ssig1(input logic [31:0] x);
        ssig1 = rotr(x, 17) ^ rotr(x, 19) ^ (x >> 10);
    endfunction
    function automatic logic [31:0] bsig0(input logic [31:0] x);
        bsig0 = rotr(x, 2) ^ rotr(x, 13) ^ rotr(x, 22);
    endfunction
    function automatic logic [31:0] bsig1(input logic [31:0] x);
        bsig1 = rotr(x, 6) ^ rotr(x, 11) ^ rotr(x, 25);
    endfunction
endpackage
`default_nettype wire

FILE: rtl/sha_core.sv
// Compression core: working variables, 16-word schedule window, one round a cycle.
`default_nettype none
module sha_core (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire sha_pkg::t_core_ctl i_ctl,
    input  wire logic [31:0]       i_h [8],
    input  wire logic [31:0]       i_w,
    input  wire logic              i_w_load,
    output logic [31:0]            o_v [8],
    output logic                   o_done
);
    import sha_pkg::*;
    logic [31:0] r_w [16];
    logic [31:0] r_v [8];
    logic [5:0]  r_t;
    logic        r_busy, r_done;
    logic [31:0] n_wnew, wt, t1, t2;

    always_comb begin
        n_wnew = r_w[0] + ssig0(r_w[1]) + r_w[9] + ssig1(r_w[14]);
        wt = r_w[0];
        t1 = r_v[7] + bsig1(r_v[4]) + ((r_v[4] & r_v[5]) ^ (~r_v[4] & r_v[6]))
             + K_TAB[r_t] + wt;
        t2 = bsig0(r_v[0]) + ((r_v[0] & r_v[1]) ^ (r_v[0] & r_v[2]) ^ (r_v[1] & r_v[2]));
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_t    <= '0;
        end else begin
            r_done <= r_busy && !i_ctl.start && (r_t == 6'd63);
            if (i_w_load) begin
                for (int i = 0; i < 15; i++) r_w[i] <= r_w[i+1];
                r_w[15] <= i_w;
            end
            if (i_ctl.start) begin
                r_busy <= 1'b1;
                r_t    <= '0;
                for (int i = 0; i < 8; i++) r_v[i] <= i_h[i];
            end else if (r_busy) begin
                for (int i = 0; i < 15; i++) r_w[i] <= r_w[i+1];
                r_w[15] <= n_wnew;
                r_v[7] <= r_v[6]; r_v[6] <= r_v[5]; r_v[5] <= r_v[4];
                r_v[4] <= r_v[3] + t1;
                r_v[3] <= r_v[2]; r_v[2] <= r_v[1]; r_v[1] <= r_v[0];
                r_v[0] <= t1 + t2;
                r_t <= r_t + 6'd1;
                if (r_t == 6'd63) r_busy <= 1'b0;
            end
        end
    end
    assign o_v = r_v;
    assign o_done = r_done;
endmodule
`default_nettype wire

FILE: rtl/sha256_hash_engine.sv
// SHA-256 engine: byte intake into block memory, sequencer, digest output.
//
// Input channel: one beat carries at most one message byte (byte_present)
// and an end-of-message flag; the byte of an end beat is taken first.
// Bytes are packed big-endian into a 16 x 32 block memory (synchronous,
// registered read). Each byte is accepted, then written back in a
// read-modify-write step while the input is stalled. A byte that fills
// the block stalls the input for start, load, rounds (one round per
// cycle in the core), finish and add. End of message: padding is written
// into the block memory one word a cycle, one or two compressions
// follow, then eight digest beats h0..h7 leave through an output
// register. A stalled output beat holds; the engine waits. After the
// eighth beat the chaining words return to the initial values word by
// word and the next message may start. Reset (synchronous, active low)
// restores the initial values through the same clearing pass; input is
// stalled meanwhile. Lengths wrap mod 2^61.
`default_nettype none
module sha256_hash_engine (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_valid,
    output logic                   o_stall,
    input  wire sha_pkg::t_in_beat i_data,
    output logic                   o_valid,
    input  wire logic              i_stall,
    output sha_pkg::t_out_beat     o_data
);
    import sha_pkg::*;

    logic [31:0] r_blk [16];
    logic [31:0] r_rd;
    logic [31:0] r_h [8];
    logic [60:0] r_cnt;
    t_state      r_st, n_st;
    logic [4:0]  r_i;
    logic        r_eom, r_twice, r_rmw, r_byte_pend, r_pad_blk;
    logic [7:0]  r_byte;
    logic        r_ov;
    t_out_beat   r_ob;

    logic        acc;
    logic [3:0]  rd_addr;
    t_core_ctl   ctl;
    logic [31:0] cv [8];
    logic        cdone;
    logic [5:0]  pos;
    logic [63:0] bits;
    logic [31:0] padw;
    logic [3:0]  pidx;
    logic [1:0]  bsel;
    logic [31:0] merged;

    assign pos = r_cnt[5:0];
    assign bits = {r_cnt, 3'b000};
    assign acc = i_valid && !o_stall;
    assign o_stall = (r_st != ST_IDLE) || r_rmw || r_byte_pend || r_eom;
    assign bsel = pos[1:0];
    assign pidx = 4'(r_i - 5'd1);

    always_comb begin
        merged = r_rd;
        case (bsel)
            2'd0: merged[31:24] = r_byte;
            2'd1: merged[23:16] = r_byte;
            2'd2: merged[15:8]  = r_byte;
            default: merged[7:0] = r_byte;
        endcase
    end

    // padding word pidx of the tail block (r_twice: second block of two)
    always_comb begin
        logic [5:0] base;
        base = {pidx, 2'b00};
        padw = '0;
        if (!r_twice) begin
            for (int b = 0; b < 4; b++) begin
                if (6'(base + 6'(b)) == pos) padw[31-8*b -: 8] = 8'h80;
                else if (6'(base + 6'(b)) < pos) padw[31-8*b -: 8] = r_rd[31-8*b -: 8];
            end
        end
        if (pidx == 4'd14 && !(r_eom && pos >= 6'd56 && !r_twice)) padw = bits[63:32];
        if (pidx == 4'd15 && !(r_eom && pos >= 6'd56 && !r_twice)) padw = bits[31:0];
    end

    always_comb begin
        rd_addr = pos[5:2];
        if (r_st == ST_LOAD || r_st == ST_PAD) rd_addr = r_i[3:0];
        if (r_st == ST_IDLE && !r_rmw && r_eom) rd_addr = 4'd0;
    end
    always_ff @(posedge i_clk) r_rd <= r_blk[rd_addr];

    sha_core u_core (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_ctl(ctl), .i_h(r_h),
        .i_w(r_rd), .i_w_load(r_st == ST_LOAD && r_i != 5'd0),
        .o_v(cv), .o_done(cdone));

    always_comb begin
        n_st = r_st;
        case (r_st)
            ST_IDLE: begin
                if (!r_rmw && r_byte_pend) n_st = ST_LOAD;
                else if (!r_rmw && !r_byte_pend && r_eom) n_st = ST_PAD;
            end
            ST_LOAD:  if (r_i == 5'd16) n_st = ST_ROUND;
            ST_ROUND: if (cdone) n_st = ST_ADD;
            ST_ADD: begin
                if (r_i[2:0] == 3'd7) begin
                    if (!r_eom) n_st = ST_IDLE;
                    else if (r_pad_blk && (r_twice || pos < 6'd56)) n_st = ST_EMIT;
                    else n_st = ST_PAD;
                end
            end
            ST_PAD:   if (r_i == 5'd16) n_st = ST_LOAD;
            ST_EMIT:  if (!r_ov && r_i[3]) n_st = ST_CLEAR;
            ST_CLEAR: if (r_i[2:0] == 3'd7) n_st = ST_IDLE;
            default:  n_st = ST_IDLE;
        endcase
    end

    always_comb begin
        ctl.start = (r_st == ST_LOAD && r_i == 5'd16);
    end

    always_ff @(posedge i_clk) begin
        if (r_rmw) r_blk[pos[5:2]] <= merged;
        if (r_st == ST_PAD && r_i != 5'd0) r_blk[pidx] <= padw;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st <= ST_CLEAR;
            r_i <= '0;
            r_cnt <= '0;
            r_eom <= 1'b0;
            r_twice <= 1'b0;
            r_rmw <= 1'b0;
            r_byte_pend <= 1'b0;
            r_pad_blk <= 1'b0;
            r_ov <= 1'b0;
        end else begin
            r_st <= n_st;
            r_rmw <= acc && i_data.byte_present;
            if (acc) begin
                r_byte <= i_data.data_byte;
                r_eom <= i_data.end_of_message;
                r_twice <= 1'b0;
            end
            r_byte_pend <= r_rmw && (pos == 6'd63);
            if (r_rmw) r_cnt <= r_cnt + 61'd1;
            case (r_st)
                ST_IDLE: r_i <= '0;
                ST_LOAD: r_i <= (r_i == 5'd16) ? 5'd0 : r_i + 5'd1;
                ST_ROUND: r_i <= '0;
                ST_ADD: begin
                    r_h[r_i[2:0]] <= r_h[r_i[2:0]] + cv[r_i[2:0]];
                    if (r_i[2:0] == 3'd7) begin
                        r_i <= '0;
                        r_pad_blk <= 1'b0;
                        // tail did not fit: a second padding block follows
                        if (r_eom && r_pad_blk && !r_twice && pos >= 6'd56)
                            r_twice <= 1'b1;
                    end else begin
                        r_i <= r_i + 5'd1;
                    end
                end
                ST_PAD: begin
                    r_i <= (r_i == 5'd16) ? 5'd0 : r_i + 5'd1;
                    if (r_i == 5'd16) r_pad_blk <= 1'b1;
                end
                ST_EMIT: begin
                    if (!r_ov || !i_stall) begin
                        if (!r_i[3]) begin
                            r_ov <= 1'b1;
                            r_ob.digest_word <= r_h[r_i[2:0]];
                            r_ob.word_index <= r_i[2:0];
                            r_ob.last_word <= (r_i[2:0] == 3'd7);
                            r_i <= r_i + 5'd1;
                        end else begin
                            r_ov <= 1'b0;
                            if (!r_ov) r_i <= '0;
                        end
                    end
                end
                ST_CLEAR: begin
                    r_h[r_i[2:0]] <= H_INIT[r_i[2:0]];
                    r_i <= r_i + 5'd1;
                    r_cnt <= '0;
                    r_eom <= 1'b0;
                    r_twice <= 1'b0;
                end
                default: r_i <= '0;
            endcase
        end
    end

    assign o_valid = r_ov;
    assign o_data = r_ob;
endmodule
`default_nettype wire

FILE: rtl/sha_checker.sv
// Port-level checker for the SHA-256 engine, bound to the top level.
`default_nettype none
module sha_checker (
    input wire logic               i_clk,
    input wire logic               i_rst_n,
    input wire logic               i_valid,
    input wire logic               o_stall,
    input wire logic               o_valid,
    input wire logic               i_stall,
    input wire sha_pkg::t_out_beat o_data
);
    import sha_pkg::*;
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_data))
        else $error("output beat changed while stalled");
    a_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_data.last_word == (o_data.word_index == 3'd7)))
        else $error("last_word mismatch");
    a_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> o_stall)
        else $error("input taken during digest output");
    a_next: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_stall && !o_data.last_word |=> !o_valid ||
        (o_data.word_index == $past(o_data.word_index) + 3'd1))
        else $error("digest word order broken");
endmodule
bind sha256_hash_engine sha_checker u_chk (.*);
`default_nettype wire

FILE: verif/sha256_hash_engine_test.sv
// Testbench for the byte-serial SHA-256 engine: directed and random messages checked against a built-in hash.
`timescale 1ns / 1ps
`default_nettype none
module sha256_hash_engine_test;
    import sha_pkg::*;

    localparam int unsigned TIMEOUT_NS = 20_000_000;

    logic       i_clk;
    logic       i_rst_n;
    logic       i_valid;
    logic       o_stall;
    t_in_beat   i_data;
    logic       o_valid;
    logic       i_stall;
    t_out_beat  o_data;

    sha256_hash_engine u_dut (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_valid(i_valid),
        .o_stall(o_stall),
        .i_data (i_data),
        .o_valid(o_valid),
        .i_stall(i_stall),
        .o_data (o_data)
    );

    // Hash state of the predictor.
    logic [31:0] hash_words [8];
    logic [31:0] msg_block  [16];
    logic [60:0] byte_count;

    t_in_beat   pending_beats [$];
    t_out_beat  expected_digest [$];
    int         mismatch_count;
    int         idle_pct;
    bit         stim_done;
    bit         drain_hold;

    localparam logic [31:0] IV [8] = '{
        32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
        32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19};
    localparam logic [31:0] RK [64] = '{
        32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5, 32'h3956c25b, 32'h59f111f1,
        32'h923f82a4, 32'hab1c5ed5, 32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
        32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174, 32'he49b69c1, 32'hefbe4786,
        32'h0fc19dc6, 32'h240ca1cc, 32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
        32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7, 32'hc6e00bf3, 32'hd5a79147,
        32'h06ca6351, 32'h14292967, 32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
        32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85, 32'ha2bfe8a1, 32'ha81a664b,
        32'hc24b8b70, 32'hc76c51a3, 32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
        32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5, 32'h391c0cb3, 32'h4ed8aa4a,
        32'h5b9cca4f, 32'h682e6ff3, 32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
        32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2};

    function automatic logic [31:0] ror32(logic [31:0] x, int n);
        return (x >> n) | (x << (32 - n));
    endfunction

    task automatic clear_hash();
        hash_words = IV;
        byte_count = '0;
        foreach (msg_block[i]) msg_block[i] = '0;
    endtask

    task automatic compress_block();
        logic [31:0] w [64];
        logic [31:0] v [8];
        logic [31:0] t1, t2, s0, s1;
        for (int t = 0; t < 16; t++) w[t] = msg_block[t];
        for (int t = 16; t < 64; t++) begin
            s0 = ror32(w[t-15], 7) ^ ror32(w[t-15], 18) ^ (w[t-15] >> 3);
            s1 = ror32(w[t-2], 17) ^ ror32(w[t-2], 19) ^ (w[t-2] >> 10);
            w[t] = w[t-16] + s0 + w[t-7] + s1;
        end
        v = hash_words;
        for (int t = 0; t < 64; t++) begin
            t1 = v[7] + (ror32(v[4], 6) ^ ror32(v[4], 11) ^ ror32(v[4], 25))
                 + ((v[4] & v[5]) ^ (~v[4] & v[6])) + RK[t] + w[t];
            t2 = (ror32(v[0], 2) ^ ror32(v[0], 13) ^ ror32(v[0], 22))
                 + ((v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]));
            v[7] = v[6]; v[6] = v[5]; v[5] = v[4]; v[4] = v[3] + t1;
            v[3] = v[2]; v[2] = v[1]; v[1] = v[0]; v[0] = t1 + t2;
        end
        for (int t = 0; t < 8; t++) hash_words[t] += v[t];
    endtask

    task automatic put_byte(int pos, logic [7:0] b);
        msg_block[pos / 4][(3 - pos % 4) * 8 +: 8] = b;
    endtask

    task automatic hash_beat(t_in_beat beat);
        int pos;
        logic [63:0] bits;
        t_out_beat word;
        if (beat.byte_present) begin
            pos = int'(byte_count[5:0]);
            put_byte(pos, beat.data_byte);
            byte_count = byte_count + 1'b1;
            if (pos == 63) compress_block();
        end
        if (beat.end_of_message) begin
            pos = int'(byte_count[5:0]);
            bits = {byte_count, 3'b000};
            put_byte(pos, 8'h80);
            pos++;
            if (pos > 56) begin
                while (pos < 64) put_byte(pos++, 8'h00);
                compress_block();
                pos = 0;
            end
            while (pos < 56) put_byte(pos++, 8'h00);
            msg_block[14] = bits[63:32];
            msg_block[15] = bits[31:0];
            compress_block();
            for (int k = 0; k < 8; k++) begin
                word.digest_word = hash_words[k];
                word.word_index = 3'(k);
                word.last_word = (k == 7);
                expected_digest.push_back(word);
            end
            clear_hash();
        end
    endtask

    function automatic t_in_beat mk_beat(logic [7:0] b, logic p, logic e);
        t_in_beat beat;
        beat.data_byte = b;
        beat.byte_present = p;
        beat.end_of_message = e;
        return beat;
    endfunction

    always begin
        i_clk = 1'b1; #5;
        i_clk = 1'b0; #5;
    end

    // Driver: next beat presented once the current one is taken.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_valid <= 1'b0;
        end else if (!(i_valid && o_stall)) begin
            if (pending_beats.size() > 0 && !drain_hold &&
                $urandom_range(99) >= idle_pct) begin
                hash_beat(pending_beats[0]);
                i_data  <= pending_beats.pop_front();
                i_valid <= 1'b1;
            end else begin
                i_valid <= 1'b0;
            end
        end
    end

    // Monitor: checks each digest beat against the oldest expectation.
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            i_stall <= ($urandom_range(99) < idle_pct);
            if (o_valid && !i_stall) begin
                if (expected_digest.size() == 0) begin
                    mismatch_count++;
                    if (mismatch_count <= 10)
                        $display("unexpected beat %h", o_data);
                end else begin
                    if (o_data !== expected_digest[0]) begin
                        mismatch_count++;
                        if (mismatch_count <= 10)
                            $display("digest mismatch: exp word %h idx %0d last %b, got %h %0d %b",
                                     expected_digest[0].digest_word,
                                     expected_digest[0].word_index,
                                     expected_digest[0].last_word, o_data.digest_word,
                                     o_data.word_index, o_data.last_word);
                    end
                    void'(expected_digest.pop_front());
                end
            end
        end
    end

    task automatic queue_message(int len, bit noisy);
        for (int i = 0; i < len; i++) begin
            if (noisy && $urandom_range(9) == 0)
                pending_beats.push_back(mk_beat(8'($urandom), 1'b0, 1'b0));
            pending_beats.push_back(mk_beat(8'($urandom), 1'b1, 1'b0));
        end
        if ($urandom_range(1))
            pending_beats.push_back(mk_beat(8'($urandom), 1'b1, 1'b1));
        else
            pending_beats.push_back(mk_beat(8'($urandom), 1'b0, 1'b1));
    endtask

    initial begin
        int lens [4];
        mismatch_count = 0;
        idle_pct = 34;
        stim_done = 0;
        drain_hold = 0;
        i_rst_n = 1'b0;
        i_valid = 1'b0;
        i_stall = 1'b0;
        i_data = '0;
        clear_hash();
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed: empty message, absent bytes, extreme values, a short message.
        pending_beats.push_back(mk_beat(8'hff, 1'b0, 1'b1));
        pending_beats.push_back(mk_beat(8'hff, 1'b0, 1'b0));
        pending_beats.push_back(mk_beat(8'h00, 1'b1, 1'b0));
        pending_beats.push_back(mk_beat(8'hff, 1'b1, 1'b1));
        pending_beats.push_back(mk_beat(8'h5a, 1'b1, 1'b1));
        pending_beats.push_back(mk_beat(8'ha5, 1'b0, 1'b1));
        for (int i = 0; i < 12; i++)
            pending_beats.push_back(mk_beat(8'(8'h11 * i), 1'b1, 1'b0));
        pending_beats.push_back(mk_beat(8'h80, 1'b1, 1'b1));
        wait (pending_beats.size() == 0);

        // Pause the sender until every digest beat has drained.
        drain_hold = 1;
        wait (expected_digest.size() == 0);
        drain_hold = 0;

        // Lengths around the block and padding boundaries.
        lens = '{55, 56, 63, 64};
        foreach (lens[i]) queue_message(lens[i] - 1, 0);
        // Quiet stretch without idling on either side.
        wait (pending_beats.size() == 0);
        idle_pct = 0;
        for (int m = 0; m < 4; m++) queue_message($urandom_range(20), 1);
        wait (pending_beats.size() == 0);
        idle_pct = 34;
        // Random messages, short.
        for (int m = 0; m < 2; m++)
            queue_message($urandom_range(12), 1);
        wait (pending_beats.size() == 0);
        wait (expected_digest.size() == 0);
        repeat (200) @(posedge i_clk);
        if (mismatch_count == 0 && expected_digest.size() == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

    initial begin
        #(TIMEOUT_NS);
        $display("CHECK FAILED");
        $finish;
    end
endmodule
`default_nettype wire

FILE: sim.f
rtl/sha_pkg.sv
rtl/sha_core.sv
rtl/sha256_hash_engine.sv
rtl/sha_checker.sv
verif/sha256_hash_engine_test.sv
